// ===== rtl/tmc_pkg.sv =====
// Shared types, constants and register codes for the temperature mode controller.
package tmc_pkg;

    localparam int unsigned DEFAULT_DUTY_BITS = 9;

    localparam int unsigned TEMP_W     = 15;
    localparam int unsigned DUTY_W     = 9;
    localparam int unsigned GAIN_W     = 24;
    localparam int unsigned MAN_W      = 16;
    localparam int unsigned LIMIT_W    = 9;
    localparam int unsigned SUM_W      = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    typedef enum logic [1:0] {
        MODE_MANUAL = 2'd0,
        MODE_HYST   = 2'd1,
        MODE_PID    = 2'd2,
        MODE_UNSUP  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE        = 3'd0,
        REG_SETPOINT    = 3'd1,
        REG_KP          = 3'd2,
        REG_KI          = 3'd3,
        REG_KD          = 3'd4,
        REG_MAN_HEATER  = 3'd5,
        REG_MAN_COOLER  = 3'd6,
        REG_DRIVE_LIMIT = 3'd7
    } reg_idx_t;

    localparam logic [DUTY_W-1:0]        HEAT_ON_DUTY = 9'd355;
    localparam logic [DUTY_W:0]          HEATER_BASE  = 10'd200;
    localparam logic signed [TEMP_W:0]   BAND_HALF    = 16'sd50;
    localparam logic [16:0]              DRIVE_DIV    = 17'd100;
    // ceil(2^23 / 100); exact floor division for all 16-bit dividends
    localparam logic [16:0]              RECIP_100    = 17'd83887;

    localparam mode_t                    RST_MODE        = MODE_MANUAL;
    localparam logic signed [TEMP_W-1:0] RST_SETPOINT    = 15'sd2400;
    localparam logic [GAIN_W-1:0]        RST_KP          = 24'd160530;
    localparam logic [GAIN_W-1:0]        RST_KI          = 24'd3926;
    localparam logic [GAIN_W-1:0]        RST_KD          = 24'd1313807;
    localparam logic [LIMIT_W-1:0]       RST_DRIVE_LIMIT = 9'd250;

    typedef struct packed {
        mode_t                     mode;
        logic signed [TEMP_W-1:0]  setpoint;
        logic [GAIN_W-1:0]         kp;
        logic [GAIN_W-1:0]         ki;
        logic [GAIN_W-1:0]         kd;
        logic signed [MAN_W-1:0]   man_heater;
        logic signed [MAN_W-1:0]   man_cooler;
        logic [LIMIT_W-1:0]        drive_limit;
    } cfg_t;

    typedef struct packed {
        logic                      pid;
        logic                      merr;
        logic [DUTY_W-1:0]         heater;
        logic [DUTY_W-1:0]         cooler;
        logic signed [TEMP_W-1:0]  err;
        logic signed [SUM_W-1:0]   err_sum;
        logic signed [TEMP_W:0]    err_delta;
    } front_t;

    typedef struct packed {
        logic                      load;
        logic [DUTY_W-1:0]         heater;
    } held_fb_t;

endpackage

// ===== rtl/tmc_if.sv =====
// Valid/ready channel interfaces: sample input, result output, register writes.
interface tmc_sample_if import tmc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature;

    modport source (output valid, output temperature, input ready);
    modport sink   (input valid, input temperature, output ready);
endinterface

interface tmc_result_if import tmc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] heater_duty;
    logic [DUTY_W-1:0] cooler_duty;
    logic [DUTY_W-1:0] pid_drive;
    logic              mode_error;

    modport source (output valid, output heater_duty, output cooler_duty,
                    output pid_drive, output mode_error, input ready);
    modport sink   (input valid, input heater_duty, input cooler_duty,
                    input pid_drive, input mode_error, output ready);
endinterface

interface tmc_cfg_if import tmc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tmc_cfg.sv =====
// Configuration register file with reset defaults and the PID state clear strobe.
module tmc_cfg import tmc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tmc_cfg_if.sink       cfg,
    output cfg_t          cfg_regs,
    output logic          pid_clear
);

    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_regs  = cfg_reg;
    assign pid_clear = cfg.valid && (reg_idx_t'(cfg.index) == REG_MODE)
                       && (mode_t'(cfg.data[1:0]) == MODE_PID);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode        <= RST_MODE;
            cfg_reg.setpoint    <= RST_SETPOINT;
            cfg_reg.kp          <= RST_KP;
            cfg_reg.ki          <= RST_KI;
            cfg_reg.kd          <= RST_KD;
            cfg_reg.man_heater  <= '0;
            cfg_reg.man_cooler  <= '0;
            cfg_reg.drive_limit <= RST_DRIVE_LIMIT;
        end
        else if (cfg.valid)
        begin
            case (reg_idx_t'(cfg.index))
                REG_MODE:        cfg_reg.mode        <= mode_t'(cfg.data[1:0]);
                REG_SETPOINT:    cfg_reg.setpoint    <= cfg.data[TEMP_W-1:0];
                REG_KP:          cfg_reg.kp          <= cfg.data[GAIN_W-1:0];
                REG_KI:          cfg_reg.ki          <= cfg.data[GAIN_W-1:0];
                REG_KD:          cfg_reg.kd          <= cfg.data[GAIN_W-1:0];
                REG_MAN_HEATER:  cfg_reg.man_heater  <= cfg.data[MAN_W-1:0];
                REG_MAN_COOLER:  cfg_reg.man_cooler  <= cfg.data[MAN_W-1:0];
                REG_DRIVE_LIMIT: cfg_reg.drive_limit <= cfg.data[LIMIT_W-1:0];
                default:         cfg_reg.mode        <= cfg_reg.mode;
            endcase
        end
    end

endmodule

// ===== rtl/tmc_front.sv =====
// Input register, error/integrator update, manual and hysteresis duty logic.
module tmc_front import tmc_pkg::*;
#(
    parameter int unsigned DUTY_BITS = DEFAULT_DUTY_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    tmc_sample_if.sink    sample,
    input  cfg_t          cfg_regs,
    input  logic          pid_clear,
    input  held_fb_t      held_fb,
    output logic          front_valid,
    output front_t        front_data,
    input  logic          front_ready
);

    localparam logic [16:0] DUTY_MAX = 17'((64'd1 << DUTY_BITS) - 64'd1);

    logic                     in_valid_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic                     front_valid_reg;
    front_t                   front_reg;
    front_t                   front_next;
    logic signed [SUM_W-1:0]  err_sum_reg;
    logic signed [TEMP_W-1:0] last_err_reg;
    logic [DUTY_W-1:0]        held_heater_reg;
    logic [DUTY_W-1:0]        held_cooler_reg;

    logic                     load1;
    logic                     advance;
    logic signed [TEMP_W:0]   sp16;
    logic signed [TEMP_W:0]   t16;
    logic signed [TEMP_W:0]   diff;
    logic signed [TEMP_W:0]   band_lo;
    logic signed [TEMP_W:0]   band_hi;
    logic signed [SUM_W:0]    sum33;

    function automatic logic [DUTY_W-1:0] clamp_req(input logic signed [MAN_W-1:0] req);
        logic [DUTY_W-1:0] res;
        if (req[MAN_W-1])
            res = '0;
        else if ({1'b0, req} > DUTY_MAX)
            res = DUTY_MAX[DUTY_W-1:0];
        else
            res = req[DUTY_W-1:0];
        return res;
    endfunction

    assign load1        = !front_valid_reg || front_ready;
    assign advance      = in_valid_reg && load1;
    assign sample.ready = !in_valid_reg || load1;
    assign front_valid  = front_valid_reg;
    assign front_data   = front_reg;

    always_comb
    begin
        sp16    = {cfg_regs.setpoint[TEMP_W-1], cfg_regs.setpoint};
        t16     = {temp_reg[TEMP_W-1], temp_reg};
        diff    = sp16 - t16;
        band_lo = sp16 - BAND_HALF;
        band_hi = sp16 + BAND_HALF;

        front_next = '0;
        if (diff[TEMP_W] != diff[TEMP_W-1])
            front_next.err = diff[TEMP_W] ? 15'sh4000 : 15'sh3FFF;
        else
            front_next.err = diff[TEMP_W-1:0];

        sum33 = {err_sum_reg[SUM_W-1], err_sum_reg}
              + {{(SUM_W-TEMP_W+1){front_next.err[TEMP_W-1]}}, front_next.err};
        if (sum33[SUM_W] != sum33[SUM_W-1])
            front_next.err_sum = sum33[SUM_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            front_next.err_sum = sum33[SUM_W-1:0];

        front_next.err_delta = {front_next.err[TEMP_W-1], front_next.err}
                             - {last_err_reg[TEMP_W-1], last_err_reg};

        front_next.heater = held_heater_reg;
        front_next.cooler = held_cooler_reg;
        case (cfg_regs.mode)
            MODE_MANUAL:
            begin
                front_next.heater = clamp_req(cfg_regs.man_heater);
                front_next.cooler = clamp_req(cfg_regs.man_cooler);
            end
            MODE_HYST:
            begin
                if (t16 < band_lo)
                begin
                    front_next.heater = HEAT_ON_DUTY;
                    front_next.cooler = '0;
                end
                else if (t16 > band_hi)
                begin
                    front_next.heater = '0;
                    front_next.cooler = DUTY_MAX[DUTY_W-1:0];
                end
            end
            MODE_PID:   front_next.pid  = 1'b1;
            MODE_UNSUP: front_next.merr = 1'b1;
            default:    front_next.merr = 1'b1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
            temp_reg <= sample.temperature;
        if (advance)
            front_reg <= front_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            front_valid_reg <= 1'b0;
            err_sum_reg     <= '0;
            last_err_reg    <= '0;
            held_heater_reg <= '0;
            held_cooler_reg <= '0;
        end
        else
        begin
            if (sample.ready)
                in_valid_reg <= sample.valid;
            if (load1)
                front_valid_reg <= in_valid_reg;

            if (pid_clear)
            begin
                err_sum_reg  <= '0;
                last_err_reg <= '0;
            end
            else if (advance && front_next.pid)
            begin
                err_sum_reg  <= front_next.err_sum;
                last_err_reg <= front_next.err;
            end

            if (held_fb.load)
                held_heater_reg <= held_fb.heater;
            else if (advance && !front_next.pid && !front_next.merr)
            begin
                held_heater_reg <= front_next.heater;
                held_cooler_reg <= front_next.cooler;
            end
        end
    end

    a_clear_pid: assert property (@(posedge clk) disable iff (!rst_n)
        pid_clear |=> (err_sum_reg == '0 && last_err_reg == '0))
        else $error("PID state not cleared after mode write");

endmodule

// ===== rtl/tmc_pid.sv =====
// PID pipeline: gain products, sum, scaling and clamp, heater offset, result register.
module tmc_pid import tmc_pkg::*;
#(
    parameter int unsigned DUTY_BITS = DEFAULT_DUTY_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          front_valid,
    input  front_t        front_data,
    output logic          front_ready,
    input  cfg_t          cfg_regs,
    output held_fb_t      held_fb,
    tmc_result_if.source  result
);

    localparam logic [16:0] DUTY_MAX = 17'((64'd1 << DUTY_BITS) - 64'd1);

    typedef struct packed {
        logic              pid;
        logic              merr;
        logic [DUTY_W-1:0] heater;
        logic [DUTY_W-1:0] cooler;
    } pass_t;

    logic               v2_reg;
    logic               v3_reg;
    logic               v4_reg;
    logic               out_valid_reg;
    pass_t              pass2_reg;
    pass_t              pass3_reg;
    pass_t              pass4_reg;
    logic signed [39:0] p_kp_reg;
    logic signed [56:0] p_ki_reg;
    logic signed [40:0] p_kd_reg;
    logic signed [57:0] s_reg;
    logic               pos_reg;
    logic               over_reg;
    logic [15:0]        xs_reg;
    logic [DUTY_W-1:0]  heater_reg;
    logic [DUTY_W-1:0]  cooler_reg;
    logic [DUTY_W-1:0]  drive_reg;
    logic               merr_reg;

    logic               load2;
    logic               load3;
    logic               load4;
    logic               out_load;
    logic signed [39:0] p_kp_next;
    logic signed [56:0] p_ki_next;
    logic signed [40:0] p_kd_next;
    logic signed [57:0] s_next;
    logic [41:0]        x_scaled;
    logic [16:0]        bound;
    logic [32:0]        q_full;
    logic [DUTY_W-1:0]  drive_next;
    logic [DUTY_W:0]    heat_sum;
    logic [DUTY_W-1:0]  heater_next;
    pass_t              pass_in;

    assign out_load    = !out_valid_reg || result.ready;
    assign load4       = !v4_reg || out_load;
    assign load3       = !v3_reg || load4;
    assign load2       = !v2_reg || load3;
    assign front_ready = load2;

    assign pass_in = '{pid: front_data.pid, merr: front_data.merr,
                       heater: front_data.heater, cooler: front_data.cooler};

    always_comb
    begin
        p_kp_next = $signed({1'b0, cfg_regs.kp}) * $signed(front_data.err);
        p_ki_next = $signed({1'b0, cfg_regs.ki}) * $signed(front_data.err_sum);
        p_kd_next = $signed({1'b0, cfg_regs.kd}) * $signed(front_data.err_delta);

        s_next = 58'(p_kp_reg) + 58'(p_ki_reg) + 58'(p_kd_reg);

        // drive exceeds the limit exactly when (s >> 16) >= 100 * (limit + 1)
        x_scaled = s_reg[57:16];
        bound    = 17'(({8'd0, cfg_regs.drive_limit} + 17'd1) * DRIVE_DIV);

        q_full = {17'd0, xs_reg} * {16'd0, RECIP_100};
        if (!pass4_reg.pid || !pos_reg)
            drive_next = '0;
        else if (over_reg)
            drive_next = cfg_regs.drive_limit;
        else
            drive_next = q_full[31:23];

        heat_sum = {1'b0, drive_next} + HEATER_BASE;
        if (!pass4_reg.pid)
            heater_next = pass4_reg.heater;
        else if ({7'd0, heat_sum} > DUTY_MAX)
            heater_next = DUTY_MAX[DUTY_W-1:0];
        else
            heater_next = heat_sum[DUTY_W-1:0];
    end

    assign held_fb.load   = out_load && v4_reg && pass4_reg.pid;
    assign held_fb.heater = heater_next;

    always_ff @(posedge clk)
    begin
        if (load2 && front_valid)
        begin
            pass2_reg <= pass_in;
            p_kp_reg  <= p_kp_next;
            p_ki_reg  <= p_ki_next;
            p_kd_reg  <= p_kd_next;
        end
        if (load3 && v2_reg)
        begin
            pass3_reg <= pass2_reg;
            s_reg     <= s_next;
        end
        if (load4 && v3_reg)
        begin
            pass4_reg <= pass3_reg;
            pos_reg   <= !s_reg[57] && (s_reg != '0);
            over_reg  <= x_scaled >= {25'd0, bound};
            xs_reg    <= x_scaled[15:0];
        end
        if (out_load && v4_reg)
        begin
            heater_reg <= heater_next;
            cooler_reg <= pass4_reg.cooler;
            drive_reg  <= drive_next;
            merr_reg   <= pass4_reg.merr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load2)
                v2_reg <= front_valid;
            if (load3)
                v3_reg <= v2_reg;
            if (load4)
                v4_reg <= v3_reg;
            if (out_load)
                out_valid_reg <= v4_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.heater_duty = heater_reg;
    assign result.cooler_duty = cooler_reg;
    assign result.pid_drive   = drive_reg;
    assign result.mode_error  = merr_reg;

    a_err_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.mode_error |-> result.pid_drive == '0)
        else $error("drive reported with mode error");

    a_nonpos_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && v4_reg && !pos_reg |=> result.pid_drive == '0)
        else $error("drive nonzero for non-positive PID sum");

    a_heater_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && v4_reg && pass4_reg.pid && ({7'd0, heat_sum} <= DUTY_MAX)
        |=> result.heater_duty == $past(heat_sum[DUTY_W-1:0]))
        else $error("heater duty does not follow PID drive");

endmodule

// ===== rtl/temperature_mode_controller_top.sv =====
// Top level of the temperature mode controller.
//
//  channel   dir  handshake      payload
//  sample    in   valid/ready    temperature (15b signed, centidegrees)
//  result    out  valid/ready    heater_duty, cooler_duty, pid_drive (9b), mode_error
//  cfg       in   valid/ready    index (3b), data (24b)
//
//  One item per cycle while result is ready; a sample passes the input reg, error
//  stage, three PID stages (multiply, sum, scale) and the result reg.
//  Each stage has its own valid and stalls only when the stage after it is full.
//  Reset loads register defaults and clears integrator, last error and held duties.
//  Writing mode PID clears the integrator and last error. cfg is always ready.
module temperature_mode_controller_top import tmc_pkg::*;
#(
    parameter int unsigned DUTY_BITS = DEFAULT_DUTY_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    tmc_sample_if.sink    sample,
    tmc_result_if.source  result,
    tmc_cfg_if.sink       cfg
);

    cfg_t     cfg_regs;
    logic     pid_clear;
    held_fb_t held_fb;
    logic     front_valid;
    front_t   front_data;
    logic     front_ready;

    tmc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_regs  (cfg_regs),
        .pid_clear (pid_clear)
    );

    tmc_front #(
        .DUTY_BITS (DUTY_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample),
        .cfg_regs    (cfg_regs),
        .pid_clear   (pid_clear),
        .held_fb     (held_fb),
        .front_valid (front_valid),
        .front_data  (front_data),
        .front_ready (front_ready)
    );

    tmc_pid #(
        .DUTY_BITS (DUTY_BITS)
    ) u_pid (
        .clk         (clk),
        .rst_n       (rst_n),
        .front_valid (front_valid),
        .front_data  (front_data),
        .front_ready (front_ready),
        .cfg_regs    (cfg_regs),
        .held_fb     (held_fb),
        .result      (result)
    );

endmodule
